// ===== hw/rtl/haversine_distance_macros.svh =====
// ----------------------------------------------------------------------------
// haversine_distance_macros
// Assertion macros used by the haversine distance RTL.
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH
`ifndef SYNTHESIS
// property must hold on every clock edge outside reset
`define HD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define HD_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HD_ASSERT(lbl, clk, rst, prop, msg)
`define HD_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== hw/rtl/hd_pkg.sv =====
// ----------------------------------------------------------------------------
// hd_pkg
// Widths, fixed-point constants and elaboration-time CORDIC tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hd_pkg;

   localparam int MUL_LAT     = 3;
   localparam int SQRT_STAGES = 32;
   localparam int ANG_W       = 44;
   localparam int ROT_W       = 44;
   localparam int VEC_W       = 54;

   localparam logic signed [29:0] LAT_LIMIT = 30'sd94371840;
   localparam logic signed [29:0] LAT_NEG   = -30'sd94371840;
   localparam logic signed [29:0] LON_LIMIT = 30'sd188743680;
   localparam logic signed [29:0] LON_NEG   = -30'sd188743680;
   localparam logic signed [29:0] LON_TURN  = 30'sd377487360;

   localparam logic [22:0] RADIUS_RESET = 23'd6378137;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] KRAD   = ((PI_Q60 / 64'd180) + (64'd1 << 18)) >> 19;
   localparam logic [63:0] ONE60  = 64'd1 << 60;
   localparam logic [63:0] ONE62  = 64'd1 << 62;

   localparam logic signed [ROT_W-1:0] ONE40 = 44'sh100_0000_0000;

   // shift-subtract division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      int i;
      r = '0;
      q = '0;
      for (i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) in Q40, series summed in Q60
   function automatic logic [ANG_W-1:0] atan_q40(input int i);
      logic [63:0] acc;
      logic [63:0] term;
      logic [63:0] tmp;
      int k;
      int e;
      acc = '0;
      if (i == 0) begin
         acc = PI_Q60 >> 2;
      end else begin
         for (k = 0; k < 31; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
               term = udiv64(ONE60 >> e, 64'(2 * k + 1));
               if ((k & 1) != 0) acc = acc - term;
               else acc = acc + term;
            end
         end
      end
      tmp = acc + (64'd1 << 19);
      return tmp[ANG_W+19:20];
   endfunction

   // 1/An^2 in Q60 for an n-stage CORDIC
   function automatic logic [63:0] inv_gain_q60(input int n);
      logic [63:0] p;
      logic [63:0] r;
      logic [63:0] q;
      int i;
      p = ONE60;
      r = ONE60;
      q = '0;
      for (i = 0; i < n; i++) p = p + (p >> (2 * i));
      for (i = 0; i < 60; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= p) begin
            r = r - p;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/haversine_distance.sv =====
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance in centimetres between two positions given in
// 2^-20 degree, on a sphere whose radius in metres is a register.
//
//   channel   ports                                    handshake
//   request   req_lat_a, req_lon_a, req_lat_b, req_lon_b  start / busy
//   response  rsp_distance_cm, rsp_range_error           rsp_valid strobe
//   csr       csr_wdata (sphere radius, metres)           csr_we
//
// One item accepted per cycle; busy is never raised.
// From accept to strobe an item passes through two CORDIC pipelines,
// the 32-stage root and six 3-stage multipliers in series.
// Reset clears the valid line and loads the radius; no clearing pass.
// The response cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "haversine_distance_macros.svh"

module haversine_distance #(
   parameter int CORDIC_STAGES = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [27:0] req_lat_a,
   input  wire logic signed [28:0] req_lon_a,
   input  wire logic signed [27:0] req_lat_b,
   input  wire logic signed [28:0] req_lon_b,
   output logic                    rsp_valid,
   output logic             [31:0] rsp_distance_cm,
   output logic                    rsp_range_error,
   input  wire logic               csr_we,
   input  wire logic        [22:0] csr_wdata
);

   localparam int ML      = hd_pkg::MUL_LAT;
   localparam int AW      = hd_pkg::ANG_W;
   localparam int RW      = hd_pkg::ROT_W;
   localparam int VW      = hd_pkg::VEC_W;
   localparam int D_TAIL  = 2 * CORDIC_STAGES + 6 * ML + 4 + hd_pkg::SQRT_STAGES;
   localparam int RSP_LAT = D_TAIL + 3;
   localparam logic [63:0] INV2 = hd_pkg::inv_gain_q60(CORDIC_STAGES);

   logic req_fire;

   assign busy     = 1'b0;
   assign req_fire = start && !busy;

   // radius register
   logic [22:0] radius_ff;
   logic [30:0] r200_ff;

   always_ff @(posedge clock) begin
      if (reset) radius_ff <= hd_pkg::RADIUS_RESET;
      else if (csr_we) radius_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      r200_ff <= {1'b0, radius_ff, 7'b0} + {2'b0, radius_ff, 6'b0} + {5'b0, radius_ff, 3'b0};
   end

   // input capture
   logic               v0_ff;
   logic signed [27:0] lat_a_ff, lat_b_ff;
   logic signed [28:0] lon_a_ff, lon_b_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= req_fire;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         lat_a_ff <= req_lat_a;
         lon_a_ff <= req_lon_a;
         lat_b_ff <= req_lat_b;
         lon_b_ff <= req_lon_b;
      end
   end

   // range check, differences, magnitudes
   logic signed [29:0] lat_a_x, lat_b_x, lon_a_x, lon_b_x;
   logic signed [29:0] dlon_raw, dlon_w;
   logic signed [29:0] ang_raw [4];
   logic        [29:0] mag_in  [4];
   logic        [3:0]  neg_in;
   logic               err_in;

   always_comb begin
      lat_a_x  = {{2{lat_a_ff[27]}}, lat_a_ff};
      lat_b_x  = {{2{lat_b_ff[27]}}, lat_b_ff};
      lon_a_x  = {lon_a_ff[28], lon_a_ff};
      lon_b_x  = {lon_b_ff[28], lon_b_ff};
      err_in   = lat_a_x > hd_pkg::LAT_LIMIT || lat_a_x < hd_pkg::LAT_NEG ||
                 lat_b_x > hd_pkg::LAT_LIMIT || lat_b_x < hd_pkg::LAT_NEG ||
                 lon_a_x > hd_pkg::LON_LIMIT || lon_a_x < hd_pkg::LON_NEG ||
                 lon_b_x > hd_pkg::LON_LIMIT || lon_b_x < hd_pkg::LON_NEG;
      dlon_raw = lon_a_x - lon_b_x;
      if (dlon_raw > hd_pkg::LON_LIMIT) dlon_w = dlon_raw - hd_pkg::LON_TURN;
      else if (dlon_raw < hd_pkg::LON_NEG) dlon_w = dlon_raw + hd_pkg::LON_TURN;
      else dlon_w = dlon_raw;
      ang_raw[0] = {lat_a_ff[27], lat_a_ff, 1'b0};
      ang_raw[1] = {lat_b_ff[27], lat_b_ff, 1'b0};
      ang_raw[2] = lat_a_x - lat_b_x;
      ang_raw[3] = dlon_w;
      for (int k = 0; k < 4; k++) begin
         neg_in[k] = ang_raw[k][29];
         mag_in[k] = neg_in[k] ? 30'(-ang_raw[k]) : 30'(ang_raw[k]);
      end
   end

   logic        v1_ff, err1_ff;
   logic [29:0] mag1_ff [4];
   logic [3:0]  neg1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= v0_ff;
   end

   always_ff @(posedge clock) begin
      err1_ff <= err_in;
      neg1_ff <= neg_in;
      for (int k = 0; k < 4; k++) mag1_ff[k] <= mag_in[k];
   end

   // degrees to Q40 radians
   logic [63:0] rad_p [4];
   logic [3:0]  neg_d;

   for (genvar k = 0; k < 4; k++) begin : g_rad
      hd_mul #(.SHIFT(0)) u_mul (
         .clock (clock),
         .a_in  ({34'b0, mag1_ff[k]}),
         .b_in  (hd_pkg::KRAD),
         .p_out (rad_p[k])
      );
   end

   hd_delay #(.WIDTH(4), .DEPTH(ML)) u_neg_dly (
      .clock (clock),
      .reset (reset),
      .d_in  (neg1_ff),
      .d_out (neg_d)
   );

   logic signed [AW-1:0] ang2_ff [4];

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         logic [63:0] rsum;
         logic [AW-1:0] rmag;
         rsum = rad_p[k] + (64'd1 << 21);
         rmag = {2'b0, rsum[63:22]};
         ang2_ff[k] <= neg_d[k] ? -rmag : rmag;
      end
   end

   // sine and cosine
   logic signed [RW-1:0] xr [4];
   logic signed [RW-1:0] yr [4];

   for (genvar k = 0; k < 4; k++) begin : g_rot
      hd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot (
         .clock (clock),
         .z_in  (ang2_ff[k]),
         .x_out (xr[k]),
         .y_out (yr[k])
      );
   end

   logic [63:0] sd_ff, so_ff, ca_ff, cb_ff;

   always_ff @(posedge clock) begin
      sd_ff <= {20'b0, yr[2][RW-1] ? RW'(-yr[2]) : RW'(yr[2])};
      so_ff <= {20'b0, yr[3][RW-1] ? RW'(-yr[3]) : RW'(yr[3])};
      ca_ff <= xr[0][RW-1] ? 64'd0 : {20'b0, xr[0]};
      cb_ff <= xr[1][RW-1] ? 64'd0 : {20'b0, xr[1]};
   end

   // haversine term h
   logic [63:0] s1, s2, cc, t1, tt, s1_d, hq;

   hd_mul #(.SHIFT(20)) u_s1 (.clock(clock), .a_in(sd_ff), .b_in(sd_ff), .p_out(s1));
   hd_mul #(.SHIFT(20)) u_s2 (.clock(clock), .a_in(so_ff), .b_in(so_ff), .p_out(s2));
   hd_mul #(.SHIFT(20)) u_cc (.clock(clock), .a_in(ca_ff), .b_in(cb_ff), .p_out(cc));
   hd_mul #(.SHIFT(60)) u_t1 (.clock(clock), .a_in(cc),    .b_in(s2),    .p_out(t1));
   hd_mul #(.SHIFT(60)) u_tt (.clock(clock), .a_in(t1),    .b_in(INV2),  .p_out(tt));

   hd_delay #(.WIDTH(64), .DEPTH(2 * ML)) u_s1_dly (
      .clock (clock),
      .reset (reset),
      .d_in  (s1),
      .d_out (s1_d)
   );

   logic [63:0] hsum_ff;

   always_ff @(posedge clock) begin
      hsum_ff <= s1_d + tt;
   end

   hd_mul #(.SHIFT(60)) u_hq (.clock(clock), .a_in(hsum_ff), .b_in(INV2), .p_out(hq));

   logic [63:0] h4_ff, hb_ff;
   logic [63:0] h4_in;

   assign h4_in = (hq > hd_pkg::ONE60) ? hd_pkg::ONE62 : (hq << 2);

   always_ff @(posedge clock) begin
      h4_ff <= h4_in;
      hb_ff <= hd_pkg::ONE62 - h4_in;
   end

   // roots and central angle
   logic [31:0]   sqa, sqb;
   logic [AW-1:0] z_ang;

   hd_isqrt u_sqa (.clock(clock), .v_in(h4_ff), .r_out(sqa));
   hd_isqrt u_sqb (.clock(clock), .v_in(hb_ff), .r_out(sqb));

   hd_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec (
      .clock (clock),
      .x_in  ({{(VW-51){1'b0}}, sqb, 19'b0}),
      .y_in  ({{(VW-51){1'b0}}, sqa, 19'b0}),
      .z_out (z_ang)
   );

   // scale by radius
   logic [63:0] dist_p;

   hd_mul #(.SHIFT(39)) u_dist (
      .clock (clock),
      .a_in  ({{(64-AW){1'b0}}, z_ang}),
      .b_in  ({33'b0, r200_ff}),
      .p_out (dist_p)
   );

   logic vt, et;

   hd_delay #(.WIDTH(2), .DEPTH(D_TAIL)) u_vld_dly (
      .clock (clock),
      .reset (reset),
      .d_in  ({v1_ff, err1_ff}),
      .d_out ({vt, et})
   );

   logic        rsp_valid_ff, rsp_err_ff;
   logic [31:0] rsp_dist_ff;
   logic [63:0] dr_in;
   logic [31:0] dist_in;

   always_comb begin
      dr_in = (dist_p + 64'd1) >> 1;
      if (et) dist_in = '0;
      else if (dr_in[63:32] != '0) dist_in = 32'hFFFF_FFFF;
      else dist_in = dr_in[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= vt;
   end

   always_ff @(posedge clock) begin
      rsp_err_ff  <= et;
      rsp_dist_ff <= dist_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_error = rsp_err_ff;
   assign rsp_distance_cm = rsp_dist_ff;

   `HD_NEVER(a_err_zero, clock, reset, rsp_valid && rsp_range_error && rsp_distance_cm != '0, "range error with non-zero distance")
   `HD_ASSERT(a_rsp_follows, clock, reset, req_fire |-> ##(RSP_LAT) rsp_valid, "accepted item gave no result")
   `HD_ASSERT(a_no_ghost, clock, reset, rsp_valid |-> $past(req_fire, RSP_LAT), "result without an accepted item")

endmodule

`default_nettype wire

// ===== hw/rtl/hd_delay.sv =====
// ----------------------------------------------------------------------------
// hd_delay
// Fixed-length shift line for sideband bits travelling beside the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hd_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [WIDTH-1:0] d_in,
   output logic      [WIDTH-1:0] d_out
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) line_ff[i] <= '0;
      end else begin
         line_ff[0] <= d_in;
         for (int i = 1; i < DEPTH; i++) line_ff[i] <= line_ff[i-1];
      end
   end

   assign d_out = line_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== hw/rtl/hd_mul.sv =====
// ----------------------------------------------------------------------------
// hd_mul
// Three-stage 64x64 unsigned multiplier from 32x32 partial products;
// returns bits SHIFT+63..SHIFT of the full product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hd_mul #(
   parameter int SHIFT = 0
) (
   input  wire logic        clock,
   input  wire logic [63:0] a_in,
   input  wire logic [63:0] b_in,
   output logic      [63:0] p_out
);

   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [64:0]  mid_ff;
   logic [127:0] cat_ff;
   logic [127:0] sum_in;
   logic [63:0]  p_ff;

   always_ff @(posedge clock) begin
      ll_ff <= a_in[31:0]  * b_in[31:0];
      lh_ff <= a_in[31:0]  * b_in[63:32];
      hl_ff <= a_in[63:32] * b_in[31:0];
      hh_ff <= a_in[63:32] * b_in[63:32];
   end

   always_ff @(posedge clock) begin
      mid_ff <= {1'b0, lh_ff} + {1'b0, hl_ff};
      cat_ff <= {hh_ff, ll_ff};
   end

   assign sum_in = cat_ff + {31'b0, mid_ff, 32'b0};

   always_ff @(posedge clock) begin
      p_ff <= sum_in[SHIFT+63:SHIFT];
   end

   assign p_out = p_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hd_cordic_rot.sv =====
// ----------------------------------------------------------------------------
// hd_cordic_rot
// Pipelined rotation CORDIC: one stage per register, gives scaled
// cosine and sine of a Q40 angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hd_cordic_rot #(
   parameter int STAGES = 24
) (
   input  wire logic                               clock,
   input  wire logic signed [hd_pkg::ANG_W-1:0]    z_in,
   output logic      signed [hd_pkg::ROT_W-1:0]    x_out,
   output logic      signed [hd_pkg::ROT_W-1:0]    y_out
);

   logic signed [hd_pkg::ROT_W-1:0] x_ff [STAGES];
   logic signed [hd_pkg::ROT_W-1:0] y_ff [STAGES];
   logic signed [hd_pkg::ANG_W-1:0] z_ff [STAGES-1];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [hd_pkg::ANG_W-1:0] ATAN_I = hd_pkg::atan_q40(i);
      logic signed [hd_pkg::ROT_W-1:0] x_prev, y_prev, x_in, y_in;
      logic signed [hd_pkg::ANG_W-1:0] z_prev, z_in_stage;

      if (i == 0) begin : g_first
         assign x_prev = hd_pkg::ONE40;
         assign y_prev = '0;
         assign z_prev = z_in;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
      end

      always_comb begin
         if (z_prev >= 0) begin
            x_in       = x_prev - (y_prev >>> i);
            y_in       = y_prev + (x_prev >>> i);
            z_in_stage = z_prev - ATAN_I;
         end else begin
            x_in       = x_prev + (y_prev >>> i);
            y_in       = y_prev - (x_prev >>> i);
            z_in_stage = z_prev + ATAN_I;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i] <= x_in;
         y_ff[i] <= y_in;
      end

      if (i < STAGES - 1) begin : g_z
         always_ff @(posedge clock) begin
            z_ff[i] <= z_in_stage;
         end
      end
   end

   assign x_out = x_ff[STAGES-1];
   assign y_out = y_ff[STAGES-1];

endmodule

`default_nettype wire

// ===== hw/rtl/hd_isqrt.sv =====
// ----------------------------------------------------------------------------
// hd_isqrt
// Pipelined floor square root of a 64-bit word, one result bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hd_isqrt (
   input  wire logic        clock,
   input  wire logic [63:0] v_in,
   output logic      [31:0] r_out
);

   localparam int N = hd_pkg::SQRT_STAGES;

   logic [63:0] v_ff [N-1];
   logic [63:0] r_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] v_prev, r_prev, v_in_stage, r_in;

      if (k == 0) begin : g_first
         assign v_prev = v_in;
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[k-1];
         assign r_prev = r_ff[k-1];
      end

      always_comb begin
         if (v_prev >= r_prev + BIT) begin
            v_in_stage = v_prev - (r_prev + BIT);
            r_in       = (r_prev >> 1) + BIT;
         end else begin
            v_in_stage = v_prev;
            r_in       = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         r_ff[k] <= r_in;
      end

      if (k < N - 1) begin : g_v
         always_ff @(posedge clock) begin
            v_ff[k] <= v_in_stage;
         end
      end
   end

   assign r_out = r_ff[N-1][31:0];

endmodule

`default_nettype wire

// ===== hw/rtl/hd_cordic_vec.sv =====
// ----------------------------------------------------------------------------
// hd_cordic_vec
// Pipelined vectoring CORDIC: Q40 angle atan2(y, x), zero for y zero,
// negative residue clipped to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hd_cordic_vec #(
   parameter int STAGES = 24
) (
   input  wire logic                               clock,
   input  wire logic signed [hd_pkg::VEC_W-1:0]    x_in,
   input  wire logic signed [hd_pkg::VEC_W-1:0]    y_in,
   output logic             [hd_pkg::ANG_W-1:0]    z_out
);

   logic signed [hd_pkg::VEC_W-1:0] x_ff [STAGES-1];
   logic signed [hd_pkg::VEC_W-1:0] y_ff [STAGES-1];
   logic signed [hd_pkg::ANG_W-1:0] z_ff [STAGES];
   logic                            zero_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [hd_pkg::ANG_W-1:0] ATAN_I = hd_pkg::atan_q40(i);
      logic signed [hd_pkg::VEC_W-1:0] x_prev, y_prev, x_next, y_next;
      logic signed [hd_pkg::ANG_W-1:0] z_prev, z_in;
      logic                            zero_prev;

      if (i == 0) begin : g_first
         assign x_prev    = x_in;
         assign y_prev    = y_in;
         assign z_prev    = '0;
         assign zero_prev = (y_in == '0);
      end else begin : g_next
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
         assign zero_prev = zero_ff[i-1];
      end

      always_comb begin
         if (y_prev > 0) begin
            x_next = x_prev + (y_prev >>> i);
            y_next = y_prev - (x_prev >>> i);
            z_in   = z_prev + ATAN_I;
         end else begin
            x_next = x_prev - (y_prev >>> i);
            y_next = y_prev + (x_prev >>> i);
            z_in   = z_prev - ATAN_I;
         end
      end

      always_ff @(posedge clock) begin
         z_ff[i]    <= z_in;
         zero_ff[i] <= zero_prev;
      end

      if (i < STAGES - 1) begin : g_xy
         always_ff @(posedge clock) begin
            x_ff[i] <= x_next;
            y_ff[i] <= y_next;
         end
      end
   end

   assign z_out = (zero_ff[STAGES-1] || z_ff[STAGES-1] < 0) ? '0 : z_ff[STAGES-1];

endmodule

`default_nettype wire

// ===== bench/haversine_checker.sv =====
// ----------------------------------------------------------------------------
// haversine_checker
// Watches the request, response and csr ports of the haversine distance
// block. For each accepted item it predicts the distance and range flag in
// bit-exact fixed point, then matches responses in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haversine_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [27:0] req_lat_a,
   input  logic signed [28:0] req_lon_a,
   input  logic signed [27:0] req_lat_b,
   input  logic signed [28:0] req_lon_b,
   input  logic               rsp_valid,
   input  logic        [31:0] rsp_distance_cm,
   input  logic               rsp_range_error,
   input  logic               csr_we,
   input  logic        [22:0] csr_wdata,
   output int                 fail_count,
   output int                 pending,
   output int                 checked_count,
   output int                 error_count
);

   localparam int STAGES = 24;
   localparam longint LAT_LIM  = 94371840;
   localparam longint LON_LIM  = 188743680;
   localparam longint LON_FULL = 377487360;
   localparam longint unsigned PI60   = 64'h3243F6A8885A308D;
   localparam longint unsigned UNIT60 = 64'd1 << 60;
   localparam longint unsigned UNIT62 = 64'd1 << 62;
   localparam longint          UNIT40 = 64'sd1 << 40;

   typedef struct packed {
      logic [31:0] distance_cm;
      logic        range_error;
   } distance_t;

   distance_t       expected_distances[$];
   longint          atan_q40[STAGES];
   longint unsigned inv_gain_sq;
   longint unsigned rad_per_unit;
   logic [22:0]     radius_m;

   initial begin
      longint unsigned acc, term, p, r, q;
      int k;
      int unsigned e;
      rad_per_unit = ((PI60 / 180) + (64'd1 << 18)) >> 19;
      p = UNIT60;
      for (int i = 0; i < STAGES; i++) begin
         acc = 0;
         if (i == 0) begin
            acc = PI60 >> 2;
         end else begin
            k = 0;
            e = i;
            while (e <= 60) begin
               term = (UNIT60 >> e) / longint'(2 * k + 1);
               if (k & 1) acc = acc - term;
               else acc = acc + term;
               k++;
               e = i * (2 * k + 1);
            end
         end
         atan_q40[i] = longint'((acc + (64'd1 << 19)) >> 20);
         if (2 * i < 64) p = p + (p >> (2 * i));
      end
      r = UNIT60;
      q = 0;
      for (int i = 0; i < 60; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= p) begin
            r = r - p;
            q[0] = 1'b1;
         end
      end
      inv_gain_sq = q;
   end

   function automatic longint unsigned mul_hi(longint unsigned a, longint unsigned b, int s);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      prod = prod >> s;
      return prod[63:0];
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint to_radians(longint v);
      longint unsigned m, r;
      m = (v < 0) ? longint'(-v) : longint'(v);
      r = (m * rad_per_unit + (64'd1 << 21)) >> 22;
      return (v < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic void cordic_rotate(longint z, output longint xo, output longint yo);
      longint x, y, nx;
      x = UNIT40;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_q40[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_q40[i];
         end
         x = nx;
      end
      xo = x;
      yo = y;
   endfunction

   function automatic longint cordic_angle(longint x, longint y);
      longint z, nx;
      z = 0;
      if (y == 0) return 0;
      for (int i = 0; i < STAGES; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_q40[i];
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_q40[i];
         end
         x = nx;
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic distance_t predict_distance(longint la, longint oa, longint lb,
                                                  longint ob, logic [22:0] rad);
      distance_t res;
      longint dlat, dlon, xa, ya, xb, yb, xd, yd, xo, yo, z;
      longint unsigned sd, so, ca, cb, s1, s2, c, t, h, a, b, d;
      res = '0;
      if (la > LAT_LIM || la < -LAT_LIM || lb > LAT_LIM || lb < -LAT_LIM ||
          oa > LON_LIM || oa < -LON_LIM || ob > LON_LIM || ob < -LON_LIM) begin
         res.range_error = 1'b1;
         return res;
      end
      dlat = la - lb;
      dlon = oa - ob;
      if (dlon > LON_LIM) dlon = dlon - LON_FULL;
      else if (dlon < -LON_LIM) dlon = dlon + LON_FULL;
      cordic_rotate(to_radians(2 * la), xa, ya);
      cordic_rotate(to_radians(2 * lb), xb, yb);
      cordic_rotate(to_radians(dlat), xd, yd);
      cordic_rotate(to_radians(dlon), xo, yo);
      sd = (yd < 0) ? -yd : yd;
      so = (yo < 0) ? -yo : yo;
      ca = (xa < 0) ? 0 : xa;
      cb = (xb < 0) ? 0 : xb;
      s1 = mul_hi(sd, sd, 20);
      s2 = mul_hi(so, so, 20);
      c  = mul_hi(ca, cb, 20);
      t  = mul_hi(mul_hi(c, s2, 60), inv_gain_sq, 60);
      h  = mul_hi(s1 + t, inv_gain_sq, 60);
      if (h > UNIT60) h = UNIT60;
      h = h << 2;
      a = floor_root(h);
      b = floor_root(UNIT62 - h);
      z = cordic_angle(longint'(b << 19), longint'(a << 19));
      d = mul_hi(z, longint'(rad) * 200, 39);
      d = (d + 1) >> 1;
      if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
      res.distance_cm = d[31:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   assign pending = expected_distances.size();

   initial begin
      fail_count    = 0;
      checked_count = 0;
      error_count   = 0;
      radius_m      = 23'd6378137;
   end

   always @(posedge clock) begin
      distance_t want;
      if (reset) begin
         expected_distances.delete();
         radius_m = 23'd6378137;
      end else begin
         if (csr_we) radius_m = csr_wdata;
         if (start && !busy) begin
            want = predict_distance(req_lat_a, req_lon_a, req_lat_b, req_lon_b, radius_m);
            if (want.range_error) error_count++;
            expected_distances.push_back(want);
         end
         if (rsp_valid) begin
            if (expected_distances.size() == 0) begin
               report_mismatch("unexpected response, distance", rsp_distance_cm, 0);
            end else begin
               want = expected_distances.pop_front();
               checked_count++;
               if (rsp_distance_cm !== want.distance_cm)
                  report_mismatch("distance_cm", rsp_distance_cm, want.distance_cm);
               if (rsp_range_error !== want.range_error)
                  report_mismatch("range_error", rsp_range_error, want.range_error);
            end
         end
      end
   end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the haversine distance block with directed corner positions and
// random coordinate pairs over several sphere radii, in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int LAT_LIM = 94371840;
   localparam int LON_LIM = 188743680;
   localparam int LATENCY = 2 * 24 + 56;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [27:0] req_lat_a;
   logic signed [28:0] req_lon_a;
   logic signed [27:0] req_lat_b;
   logic signed [28:0] req_lon_b;
   logic               rsp_valid;
   logic        [31:0] rsp_distance_cm;
   logic               rsp_range_error;
   logic               csr_we;
   logic        [22:0] csr_wdata;
   int                 fail_count;
   int                 pending;
   int                 checked_count;
   int                 error_count;
   int                 item_count;
   int                 burst_left;

   haversine_distance u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_lat_a       (req_lat_a),
      .req_lon_a       (req_lon_a),
      .req_lat_b       (req_lat_b),
      .req_lon_b       (req_lon_b),
      .rsp_valid       (rsp_valid),
      .rsp_distance_cm (rsp_distance_cm),
      .rsp_range_error (rsp_range_error),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   haversine_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("testbench: FAIL");
      $finish;
   end

   // holds the item until accepted, then a gap if the burst has run out
   task automatic send_position(int la, int oa, int lb, int ob);
      start     <= 1'b1;
      req_lat_a <= 28'(la);
      req_lon_a <= 29'(oa);
      req_lat_b <= 28'(lb);
      req_lon_b <= 29'(ob);
      do @(posedge clock); while (busy);
      item_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 80)
                                                : $urandom_range(0, 12);
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic set_radius(logic [22:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int rand_lat();
      return int'($urandom_range(2 * LAT_LIM)) - LAT_LIM;
   endfunction

   function automatic int rand_lon();
      return int'($urandom_range(2 * LON_LIM)) - LON_LIM;
   endfunction

   task automatic random_items(int count);
      int la, oa;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0: send_position($urandom, $urandom, $urandom, $urandom);
            1: begin
               la = rand_lat();
               oa = rand_lon();
               send_position(la, oa, la + $urandom_range(0, 200) - 100,
                             oa + $urandom_range(0, 200) - 100);
            end
            2: send_position($urandom_range(0, 1) ? LAT_LIM : -LAT_LIM, rand_lon(),
                             rand_lat(), rand_lon());
            default: send_position(rand_lat(), rand_lon(), rand_lat(), rand_lon());
         endcase
      end
   endtask

   logic [22:0] radius_list[6];

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_lat_a  = '0;
      req_lon_a  = '0;
      req_lat_b  = '0;
      req_lon_b  = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      item_count = 0;
      burst_left = 0;
      radius_list = '{23'd6000000, 23'd7000000, 23'd8388607, 23'd0, 23'd6378137, 23'd0};
      radius_list[5] = 23'(6000000 + $urandom_range(0, 1000000));
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners at the reset radius
      send_position(0, 0, 0, 0);
      send_position(LAT_LIM, LON_LIM, -LAT_LIM, -LON_LIM);
      send_position(LAT_LIM, 0, -LAT_LIM, 0);
      send_position(0, LON_LIM, 0, -LON_LIM);
      send_position(0, LON_LIM, 0, -1);
      send_position(0, -LON_LIM, 0, 1);
      send_position(0, 0, 0, LON_LIM);
      send_position(LAT_LIM, 12345, LAT_LIM, -54321);
      send_position(-LAT_LIM, LON_LIM, -LAT_LIM, 0);
      send_position(LAT_LIM + 1, 0, 0, 0);
      send_position(0, LON_LIM + 1, 0, 0);
      send_position(0, 0, -LAT_LIM - 1, 0);
      send_position(0, 0, 0, -LON_LIM - 1);
      send_position(-(1 << 27), -(1 << 28), (1 << 27) - 1, (1 << 28) - 1);
      send_position(1, 0, 0, 0);
      send_position(0, 1, 0, 0);
      send_position(47185920, 94371840, 47185920, 94371841);
      random_items(70);

      foreach (radius_list[i]) begin
         set_radius(radius_list[i]);
         send_position(LAT_LIM, 0, -LAT_LIM, 0);
         random_items(120);
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d items over %0d radius settings: %0d responses checked, %0d out of range",
               item_count, $size(radius_list) + 1, checked_count, error_count);
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
